>>> sv/ped_pkg.sv
`default_nettype none
package ped_pkg;
  localparam int MAX_PERIODS = 8;
  localparam int MAX_EVENTS = 16;
  localparam int SLOT_W = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int EVT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int SCNT_W = $clog2(MAX_PERIODS + 1);
  localparam int ECNT_W = $clog2(MAX_EVENTS + 1);
  localparam int TICK_W = 32;
  localparam int PER_W = 16;
  localparam int ID_W = 8;
  localparam int KIND_W = 3;
  localparam int DIV_CNT_W = $clog2(TICK_W);

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FIRED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  typedef struct packed {
    logic load;
    logic start_div;
    logic add_known;
    logic add_new;
    logic reg_result;
    logic [KIND_W-1:0] reg_kind;
    logic walk;
    logic tick_result;
  } ped_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic zero_period;
    logic events_full;
    logic slots_full;
    logic found;
    logic div_done;
    logic out_free;
    logic walk_done;
  } ped_stat_t;
endpackage
`default_nettype wire

>>> sv/ped_div.sv
`default_nettype none
module ped_div import ped_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TICK_W-1:0] dividend,
  input  wire logic [PER_W-1:0]  divisor,
  output logic                   done,
  output logic [PER_W-1:0]       remainder
);
  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [TICK_W-1:0]    shift;
  logic [PER_W-1:0]     rem;
  logic [PER_W:0]       trial;
  logic [PER_W:0]       diff;
  logic                 ge;

  assign trial = {rem, shift[TICK_W-1]};
  assign diff = trial - {1'b0, divisor};
  assign ge = (trial >= {1'b0, divisor});
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        shift <= dividend;
        rem <= '0;
      end else if (busy) begin
        rem <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
        shift <= shift << 1;
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(TICK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/ped_ctrl.sv
`default_nettype none
module ped_ctrl import ped_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ped_stat_t stat,
  output ped_cmd_t       cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIVIDE, S_REPLY, S_WALK, S_FINISH
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [KIND_W-1:0] reg_kind;
  logic [KIND_W-1:0] reg_kind_next;

  always_comb begin
    state_next = state;
    reg_kind_next = reg_kind;
    cmd = '0;
    cmd.reg_kind = reg_kind;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_tick) begin
          state_next = S_WALK;
        end else if (stat.zero_period) begin
          reg_kind_next = KIND_ZERO;
          state_next = S_REPLY;
        end else if (stat.events_full) begin
          reg_kind_next = KIND_FULL;
          state_next = S_REPLY;
        end else if (stat.found) begin
          cmd.add_known = 1'b1;
          reg_kind_next = KIND_OK;
          state_next = S_REPLY;
        end else if (stat.slots_full) begin
          reg_kind_next = KIND_FULL;
          state_next = S_REPLY;
        end else begin
          cmd.start_div = 1'b1;
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          cmd.add_new = 1'b1;
          reg_kind_next = KIND_OK;
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.reg_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.tick_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reg_kind <= KIND_OK;
    end else begin
      state <= state_next;
      reg_kind <= reg_kind_next;
    end
  end
endmodule
`default_nettype wire

>>> sv/ped_dp.sv
`default_nettype none
module ped_dp import ped_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              opcode,
  input  wire logic [PER_W-1:0]  period,
  input  wire logic [ID_W-1:0]   event_id,
  input  wire logic              has_tick,
  input  wire logic              has_tock,
  input  wire ped_cmd_t          cmd,
  output ped_stat_t              stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [ID_W-1:0]        fired_id,
  output logic                   phase,
  output logic [TICK_W-1:0]      current_tick,
  output logic                   last
);
  logic                req_opcode;
  logic [PER_W-1:0]    req_period;
  logic [ID_W-1:0]     req_id;
  logic [1:0]          req_flags;

  logic [TICK_W-1:0]   tick_count;
  logic [SCNT_W-1:0]   slots_used;
  logic [ECNT_W-1:0]   events_used;
  logic [PER_W-1:0]    slot_period [MAX_PERIODS];
  logic [PER_W-1:0]    slot_rem [MAX_PERIODS];
  logic [SLOT_W-1:0]   event_slot [MAX_EVENTS];
  logic [ID_W-1:0]     event_ident [MAX_EVENTS];
  logic [1:0]          event_flags [MAX_EVENTS];

  logic                walk_phase;
  logic [SCNT_W-1:0]   slot_cur;
  logic [ECNT_W-1:0]   ev_cur;
  logic                hold_valid;
  logic [ID_W-1:0]     hold_id;
  logic                hold_phase;

  logic                found;
  logic [SLOT_W-1:0]   found_idx;
  logic [SCNT_W-1:0]   slot_dec;
  logic [SLOT_W-1:0]   slot_idx;
  logic                slot_due;
  logic                hit_any;
  logic [EVT_W-1:0]    hit_idx;
  logic                out_free;
  logic                walk_emit;
  logic                div_done;
  logic [PER_W-1:0]    div_rem;
  logic [SLOT_W-1:0]   new_slot;
  logic [EVT_W-1:0]    evt_wr_idx;

  ped_div u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.start_div),
    .dividend(tick_count),
    .divisor(req_period),
    .done(div_done),
    .remainder(div_rem)
  );

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    for (int i = 0; i < MAX_PERIODS; i++) begin
      if ((SCNT_W'(i) < slots_used) && (slot_period[i] == req_period)) begin
        found = 1'b1;
        found_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_dec = slot_cur - SCNT_W'(1);
  assign slot_idx = slot_dec[SLOT_W-1:0];
  assign slot_due = (slot_rem[slot_idx] == '0);
  assign new_slot = slots_used[SLOT_W-1:0];
  assign evt_wr_idx = events_used[EVT_W-1:0];

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      if ((ECNT_W'(i) < ev_cur) && (event_slot[i] == slot_idx) &&
          event_flags[i][walk_phase]) begin
        hit_any = 1'b1;
        hit_idx = EVT_W'(i);
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign walk_emit = cmd.walk && (slot_cur != '0) && slot_due && hit_any &&
                     hold_valid && out_free;

  assign stat.is_tick = (req_opcode == OP_TICK);
  assign stat.zero_period = (req_period == '0);
  assign stat.events_full = (events_used == ECNT_W'(MAX_EVENTS));
  assign stat.slots_full = (slots_used == SCNT_W'(MAX_PERIODS));
  assign stat.found = found;
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;
  assign stat.walk_done = walk_phase && (slot_cur == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_opcode <= opcode;
      req_period <= period;
      req_id <= event_id;
      req_flags <= {has_tock, has_tick};
    end
    if (cmd.add_known) begin
      event_slot[evt_wr_idx] <= found_idx;
      event_ident[evt_wr_idx] <= req_id;
      event_flags[evt_wr_idx] <= req_flags;
    end
    if (cmd.add_new) begin
      slot_period[new_slot] <= req_period;
      slot_rem[new_slot] <= div_rem;
      event_slot[evt_wr_idx] <= new_slot;
      event_ident[evt_wr_idx] <= req_id;
      event_flags[evt_wr_idx] <= req_flags;
    end
    if (cmd.tick_result) begin
      for (int i = 0; i < MAX_PERIODS; i++) begin
        if ((tick_count == '1) ||
            (({1'b0, slot_rem[i]} + (PER_W + 1)'(1)) == {1'b0, slot_period[i]})) begin
          slot_rem[i] <= '0;
        end else begin
          slot_rem[i] <= slot_rem[i] + PER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slots_used <= '0;
      events_used <= '0;
      walk_phase <= 1'b0;
      slot_cur <= '0;
      ev_cur <= '0;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (walk_emit || cmd.reg_result || cmd.tick_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        walk_phase <= 1'b0;
        slot_cur <= slots_used;
        ev_cur <= events_used;
        hold_valid <= 1'b0;
      end
      if (cmd.add_known) events_used <= events_used + ECNT_W'(1);
      if (cmd.add_new) begin
        slots_used <= slots_used + SCNT_W'(1);
        events_used <= events_used + ECNT_W'(1);
      end
      if (cmd.walk) begin
        if (slot_cur == '0) begin
          if (!walk_phase) begin
            walk_phase <= 1'b1;
            slot_cur <= slots_used;
            ev_cur <= events_used;
          end
        end else if (!slot_due || !hit_any) begin
          slot_cur <= slot_dec;
          ev_cur <= events_used;
        end else if (!hold_valid || out_free) begin
          hold_valid <= 1'b1;
          hold_id <= event_ident[hit_idx];
          hold_phase <= walk_phase;
          ev_cur <= ECNT_W'(hit_idx);
        end
      end
      if (walk_emit) begin
        kind <= KIND_FIRED;
        fired_id <= hold_id;
        phase <= hold_phase;
        current_tick <= tick_count;
        last <= 1'b0;
      end
      if (cmd.reg_result) begin
        kind <= cmd.reg_kind;
        fired_id <= '0;
        phase <= 1'b0;
        current_tick <= '0;
        last <= 1'b1;
      end
      if (cmd.tick_result) begin
        kind <= hold_valid ? KIND_FIRED : KIND_NONE;
        fired_id <= hold_valid ? hold_id : '0;
        phase <= hold_valid ? hold_phase : 1'b0;
        current_tick <= tick_count;
        last <= 1'b1;
        tick_count <= tick_count + TICK_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/periodic_event_dispatcher.sv
// periodic event dispatcher
// input channel (in_valid/in_ready) takes one request: opcode 0 registers an
// event under a period, opcode 1 runs one tick of dispatch
// output channel (out_valid/out_ready) returns results; last marks the final
// result of each request
// a registration answers with one result, loaded from the reply state after the
// check state when the period slot exists or the request is rejected, and after
// the divide state when a new slot is made, set by the 32-step remainder unit
// that seeds the slot's running residue with the tick count modulo the period
// a tick walks every period slot twice, once per phase, stopping at each fired
// result: the last result is loaded from the finish state after the walk;
// nothing due gives one result with kind 4
// the next request is taken the cycle after the last result is loaded into the
// output register, which may still wait for the receiver
// a stalled receiver holds the walk at its next fired event
// reset clears the tick count, the slot and event counts and the output valid
`default_nettype none
module periodic_event_dispatcher import ped_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              opcode,
  input  wire logic [PER_W-1:0]  period,
  input  wire logic [ID_W-1:0]   event_id,
  input  wire logic              has_tick,
  input  wire logic              has_tock,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [ID_W-1:0]        fired_id,
  output logic                   phase,
  output logic [TICK_W-1:0]      current_tick,
  output logic                   last
);
  ped_cmd_t  cmd;
  ped_stat_t stat;

  ped_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat(stat),
    .cmd(cmd)
  );

  ped_dp u_dp (
    .clk(clk),
    .rst(rst),
    .opcode(opcode),
    .period(period),
    .event_id(event_id),
    .has_tick(has_tick),
    .has_tock(has_tock),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .fired_id(fired_id),
    .phase(phase),
    .current_tick(current_tick),
    .last(last)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_FIRED) |-> last)
    else $error("status result not marked last");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_FIRED) |-> (fired_id == '0) && !phase)
    else $error("status result carries event fields");

  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.walk && !cmd.start_div && !cmd.tick_result)
    else $error("work issued while idle");
`endif
endmodule
`default_nettype wire
